// File: sv/rgbc_pkg.sv
// Shared types, blend mode codes and channel conversion helpers for the
// RGB565 blend-mode compositor. No dependencies.
package rgbc_pkg;

    // Blend mode codes as carried on the mode select field.
    typedef enum logic [3:0] {
        MODE_NORMAL   = 4'd0,
        MODE_OVERLAY  = 4'd1,
        MODE_MULTIPLY = 4'd2,
        MODE_SCREEN   = 4'd3,
        MODE_ADD      = 4'd4,
        MODE_DARKEN   = 4'd5,
        MODE_LIGHTEN  = 4'd6,
        MODE_DODGE    = 4'd7,
        MODE_BURN     = 4'd8
    } t_mode;

    localparam int NUM_STAGES = 6;
    localparam logic [7:0] OP_NONE = 8'd0;
    localparam logic [7:0] OP_FULL = 8'd255;
    localparam logic [7:0] CHAN_FULL = 8'd255;

    // One flag per pixel channel: red, green, blue.
    typedef logic [2:0] t_chan_flags;

    // floor(x / 255) for x below 65280, as a shift-add.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // c * 255 / 31, truncated: 8c plus floor(7c / 31).
    function automatic logic [7:0] widen5(input logic [4:0] c);
        logic [7:0] y;
        logic [2:0] q;
        y = ({3'd0, c} << 3) - {3'd0, c};
        q = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if ({2'd0, y} >= 10'(31 * k)) begin
                q = q + 3'd1;
            end
        end
        return {c, 3'd0} + {5'd0, q};
    endfunction

    // c * 255 / 63, truncated: 4c plus floor(c / 21).
    function automatic logic [7:0] widen6(input logic [5:0] c);
        logic [1:0] q;
        q = 2'd0;
        if (c >= 6'd21) q = q + 2'd1;
        if (c >= 6'd42) q = q + 2'd1;
        if (c >= 6'd63) q = q + 2'd1;
        return {c, 2'd0} + {6'd0, q};
    endfunction

    // v * 31 / 255, truncated.
    function automatic logic [4:0] narrow5(input logic [7:0] v);
        logic [15:0] x;
        logic [7:0] q;
        x = ({8'd0, v} << 5) - {8'd0, v};
        q = div255(x);
        return q[4:0];
    endfunction

    // v * 63 / 255, truncated.
    function automatic logic [5:0] narrow6(input logic [7:0] v);
        logic [15:0] x;
        logic [7:0] q;
        x = ({8'd0, v} << 6) - {8'd0, v};
        q = div255(x);
        return q[5:0];
    endfunction

endpackage

// File: sv/rgb565_blend_mode_compositor.sv
// Top level of the RGB565 blend-mode compositor: six-stage pixel pipeline.
// Depends on rgbc_pkg, rgbc_mode and rgbc_mix.
//
//   Channel   Direction  Handshake           Payload
//   --------  ---------  ------------------  ---------------------------------
//   pixel in  input      i_valid / o_ready   base color, top color, opacity,
//                                            mode select
//   pixel out output     o_valid / i_ready   result color
//
// The datapath has six register stages (capture, widen, blend mode, narrow
// and rewiden, mix product, mix and pack); the last is the output register.
// One request can be accepted on every clock while the output is not
// stalled.
// Reset is synchronous and active low; it clears only the stage valid bits.
// Each stage holds when the stage after it is full and stalled, so a stall at
// the output backs up one stage at a time and bubbles are squeezed out.
module rgb565_blend_mode_compositor
    import rgbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_base_color,
    input  logic [15:0] i_top_color,
    input  logic [7:0]  i_opacity,
    input  logic [3:0]  i_mode_select,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result_color
);

    localparam int LAST = NUM_STAGES - 1;

    // Stage valid bits and per-stage load enables.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] rdy;

    // Stage 0: captured request.
    logic [15:0] r0_base, r0_top;
    logic [7:0]  r0_op;
    logic [3:0]  r0_mode;

    // Stage 1: widened channels of base and top.
    logic [7:0]  r1_a [3];
    logic [7:0]  r1_b [3];
    logic [15:0] r1_base;
    logic [7:0]  r1_op;
    logic [3:0]  r1_mode;

    // Stage 2: blend mode result per channel.
    logic [7:0]  r2_v [3];
    logic [7:0]  r2_a [3];
    logic [15:0] r2_base;
    logic [7:0]  r2_op;

    // Stage 3: narrowed mode pixel and its rewidened channels.
    logic [15:0] r3_m565;
    logic [7:0]  r3_mb [3];
    logic [7:0]  r3_a [3];
    logic [15:0] r3_base;
    logic [7:0]  r3_op;

    // Stage 4: signed mix products.
    logic signed [16:0] r4_prod [3];
    logic [7:0]  r4_a [3];
    logic [15:0] r4_base;
    logic [15:0] r4_m565;
    logic [7:0]  r4_op;

    // Stage 5: output register.
    logic [15:0] r5_res;

    // Combinational values between stages.
    logic [7:0]  mode_v [3];
    logic [15:0] n3_m565;
    logic signed [8:0]  diff [3];
    logic signed [16:0] n4_prod [3];
    logic [7:0]  mix_v [3];
    logic [15:0] n5_res;

    // Ready flows back from the output: a stage loads when it is empty or
    // when the stage after it loads in the same cycle.
    always_comb begin
        rdy[LAST] = !r_vld[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready        = rdy[0];
    assign o_valid        = r_vld[LAST];
    assign o_result_color = r5_res;

    // Blend mode per channel.
    for (genvar c = 0; c < 3; c++) begin : g_mode
        rgbc_mode u_mode (
            .i_a    (r1_a[c]),
            .i_b    (r1_b[c]),
            .i_mode (r1_mode),
            .o_v    (mode_v[c])
        );
    end

    // Narrowing back to RGB565 and widening again for the opacity mix.
    assign n3_m565 = {narrow5(r2_v[0]), narrow6(r2_v[1]), narrow5(r2_v[2])};

    // Mix products: (mode - base) * opacity, signed.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c]    = $signed({1'b0, r3_mb[c]}) - $signed({1'b0, r3_a[c]});
            n4_prod[c] = diff[c] * $signed({1'b0, r3_op});
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_mix
        rgbc_mix u_mix (
            .i_a    (r4_a[c]),
            .i_prod (r4_prod[c]),
            .o_v    (mix_v[c])
        );
    end

    // Zero opacity passes the base through untouched; full opacity takes the
    // mode pixel without a second round of widening and narrowing.
    always_comb begin
        if (r4_op == OP_NONE) begin
            n5_res = r4_base;
        end else if (r4_op == OP_FULL) begin
            n5_res = r4_m565;
        end else begin
            n5_res = {narrow5(mix_v[0]), narrow6(mix_v[1]), narrow5(mix_v[2])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_base <= i_base_color;
            r0_top  <= i_top_color;
            r0_op   <= i_opacity;
            r0_mode <= i_mode_select;
        end
        if (rdy[1]) begin
            r1_a[0] <= widen5(r0_base[15:11]);
            r1_a[1] <= widen6(r0_base[10:5]);
            r1_a[2] <= widen5(r0_base[4:0]);
            r1_b[0] <= widen5(r0_top[15:11]);
            r1_b[1] <= widen6(r0_top[10:5]);
            r1_b[2] <= widen5(r0_top[4:0]);
            r1_base <= r0_base;
            r1_op   <= r0_op;
            r1_mode <= r0_mode;
        end
        if (rdy[2]) begin
            r2_v    <= mode_v;
            r2_a    <= r1_a;
            r2_base <= r1_base;
            r2_op   <= r1_op;
        end
        if (rdy[3]) begin
            r3_m565  <= n3_m565;
            r3_mb[0] <= widen5(n3_m565[15:11]);
            r3_mb[1] <= widen6(n3_m565[10:5]);
            r3_mb[2] <= widen5(n3_m565[4:0]);
            r3_a     <= r2_a;
            r3_base  <= r2_base;
            r3_op    <= r2_op;
        end
        if (rdy[4]) begin
            r4_prod <= n4_prod;
            r4_a    <= r3_a;
            r4_base <= r3_base;
            r4_m565 <= r3_m565;
            r4_op   <= r3_op;
        end
        if (rdy[LAST]) begin
            r5_res <= n5_res;
        end
    end

`ifndef ASSERT_OFF
    // The input can only be held off when every stage holds a request.
    a_ready_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // Zero opacity delivers the base pixel bit for bit.
    a_zero_opacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && rdy[LAST] && (r4_op == OP_NONE))
            |=> (o_valid && (o_result_color == $past(r4_base))))
        else $error("zero opacity did not pass the base pixel");

    // Full opacity delivers the mode pixel unmixed.
    a_full_opacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && rdy[LAST] && (r4_op == OP_FULL))
            |=> (o_valid && (o_result_color == $past(r4_m565))))
        else $error("full opacity result differs from the mode pixel");

    // A held output stage keeps its request.
    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r5_res)))
        else $error("stalled output request changed");
`endif

endmodule

// File: sv/rgbc_mode.sv
// Per-channel blend mode evaluation on widened 8-bit channel values.
// Depends on rgbc_pkg for mode codes and the divide-by-255 helper.
module rgbc_mode
    import rgbc_pkg::*;
(
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    input  logic [3:0] i_mode,
    output logic [7:0] o_v
);

    logic [7:0]  inv_a;
    logic [7:0]  inv_b;
    logic [15:0] p_ab;
    logic [15:0] p_inv;
    logic [8:0]  sum;
    logic [15:0] ovl_hi;

    always_comb begin
        inv_a  = CHAN_FULL - i_a;
        inv_b  = CHAN_FULL - i_b;
        p_ab   = {8'd0, i_a} * {8'd0, i_b};
        p_inv  = {8'd0, inv_a} * {8'd0, inv_b};
        sum    = {1'b0, i_a} + {1'b0, i_b};
        ovl_hi = p_inv >> 7;

        unique case (i_mode) inside
            MODE_OVERLAY: begin
                if (!i_a[7]) begin
                    o_v = p_ab[14:7];
                end else begin
                    o_v = CHAN_FULL - ovl_hi[7:0];
                end
            end
            MODE_MULTIPLY: o_v = div255(p_ab);
            MODE_SCREEN:   o_v = CHAN_FULL - div255(p_inv);
            MODE_ADD, MODE_DODGE: begin
                o_v = sum[8] ? CHAN_FULL : sum[7:0];
            end
            MODE_DARKEN:   o_v = (i_a < i_b) ? i_a : i_b;
            MODE_LIGHTEN:  o_v = (i_a > i_b) ? i_a : i_b;
            MODE_BURN: begin
                o_v = (sum >= 9'd255) ? 8'(sum - 9'd255) : 8'd0;
            end
            default:       o_v = i_b;
        endcase
    end

endmodule

// File: sv/rgbc_mix.sv
// Opacity mix of one channel: base plus the floored, scaled difference,
// clamped to 0..255. Depends on rgbc_pkg for the channel limit.
module rgbc_mix
    import rgbc_pkg::*;
(
    input  logic [7:0]         i_a,
    input  logic signed [16:0] i_prod,
    output logic [7:0]         o_v
);

    logic signed [16:0] delta;
    logic signed [9:0]  total;

    always_comb begin
        // Arithmetic shift floors toward minus infinity for negative products.
        delta = i_prod >>> 8;
        total = $signed({2'b00, i_a}) + delta[9:0];
        if (total < 10'sd0) begin
            o_v = 8'd0;
        end else if (total > $signed({2'b00, CHAN_FULL})) begin
            o_v = CHAN_FULL;
        end else begin
            o_v = total[7:0];
        end
    end

endmodule
